### sv/qpps_pkg.sv
// ----------------------------------------------------------------------------
// qpps_pkg
// Shared types, register codes and helpers for the quadrature PI servo.
// ----------------------------------------------------------------------------
package qpps_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_TARGET = 2'd0;
	localparam logic [1:0] CFG_KP     = 2'd1;
	localparam logic [1:0] CFG_KI     = 2'd2;

	// gain reset values, unsigned Q16
	localparam logic [23:0] KP_RESET = 24'd32768;
	localparam logic [23:0] KI_RESET = 24'd655;

	// duty ceiling and fixed-point shift
	localparam logic [7:0] PWM_MAX  = 8'd255;
	localparam int         Q16_FRAC = 16;

	// snapshot of the loop state taken on a control tick
	typedef struct packed {
		logic signed [31:0] error;
		logic signed [31:0] integral;
		logic signed [31:0] position;
		logic        [31:0] bad;
	} tick_snap_t;

	// place of a pin pair along the cycle 00, 01, 11, 10
	function automatic logic [1:0] phase_of(input logic a, input logic b);
		logic [1:0] ph;
		ph = a ? (b ? 2'd2 : 2'd3) : (b ? 2'd1 : 2'd0);
		return ph;
	endfunction

	// clamp a 33-bit signed sum to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] == v[31]) begin
			r = v[31:0];
		end else if (v[32]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

### sv/qpps_encoder.sv
// ----------------------------------------------------------------------------
// qpps_encoder
// Quadrature decoder: signed position counter and bad-transition counter.
// ----------------------------------------------------------------------------
module qpps_encoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_en,
	input  logic               pin_a,
	input  logic               pin_b,
	output logic signed [31:0] position,
	output logic        [31:0] bad_count
);
	import qpps_pkg::*;

	logic               last_a_q;
	logic               last_b_q;
	logic signed [31:0] position_q;
	logic        [31:0] bad_q;
	logic        [1:0]  step;

	// distance moved along the quadrature cycle
	assign step = phase_of(pin_a, pin_b) - phase_of(last_a_q, last_b_q);

	// counters and last pin levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q   <= 1'b0;
			last_b_q   <= 1'b0;
			position_q <= '0;
			bad_q      <= '0;
		end else if (sample_en) begin
			last_a_q <= pin_a;
			last_b_q <= pin_b;
			if (step == 2'd1) begin
				position_q <= position_q + 32'sd1;
			end else if (step == 2'd3) begin
				position_q <= position_q - 32'sd1;
			end else begin
				bad_q <= bad_q + 32'd1;
			end
		end
	end

	assign position  = position_q;
	assign bad_count = bad_q;

endmodule

### sv/qpps_pi_state.sv
// ----------------------------------------------------------------------------
// qpps_pi_state
// Error and integral registers of the PI loop, saturating updates per tick.
// ----------------------------------------------------------------------------
module qpps_pi_state (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick_en,
	input  logic signed [31:0] target,
	input  logic signed [31:0] position,
	output logic signed [31:0] error_d,
	output logic signed [31:0] integral_d
);
	import qpps_pkg::*;

	logic signed [31:0] error_q;
	logic signed [31:0] integral_q;

	// integral takes the previous error, then the new error is formed
	assign integral_d = sat32(33'(integral_q) + 33'(error_q));
	assign error_d    = sat32(33'(target) - 33'(position));

	// state update on a control tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q    <= '0;
			integral_q <= '0;
		end else if (tick_en) begin
			error_q    <= error_d;
			integral_q <= integral_d;
		end
	end

endmodule

### sv/qpps_drive.sv
// ----------------------------------------------------------------------------
// qpps_drive
// Drive pipeline: gain products, Q16 truncation toward zero, duty split.
// ----------------------------------------------------------------------------
module qpps_drive (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     push_ready,
	input  qpps_pkg::tick_snap_t     snap,
	input  logic              [23:0] kp_gain,
	input  logic              [23:0] ki_gain,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic              [7:0]  pwm_forward,
	output logic              [7:0]  pwm_reverse,
	output logic signed       [31:0] loop_error,
	output logic signed       [31:0] position_now,
	output logic              [31:0] bad_transitions
);
	import qpps_pkg::*;

	localparam int AccW   = 58;
	localparam int DriveW = AccW - Q16_FRAC;

	logic                      v_s1, v_s2, v_s3, out_valid_q;
	logic                      s1_free, s2_free, s3_free, out_free;
	tick_snap_t                snap_s1, snap_s2, snap_s3;
	logic signed [56:0]        prod_p, prod_i;
	logic signed [56:0]        prod_p_s2, prod_i_s2;
	logic signed [AccW-1:0]    acc;
	logic signed [DriveW-1:0]  floor_s3;
	logic                      round_s3;
	logic        [DriveW-1:0]  mag;
	logic        [7:0]         fwd, rev;
	logic        [7:0]         fwd_q, rev_q;
	tick_snap_t                snap_q;

	// a stage moves when the one after it has room
	assign out_free   = !out_valid_q || !out_stall;
	assign s3_free    = !v_s3 || out_free;
	assign s2_free    = !v_s2 || s3_free;
	assign s1_free    = !v_s1 || s2_free;
	assign push_ready = s1_free;

	// gain products, unsigned gains widened by a zero sign bit
	assign prod_p = $signed({1'b0, kp_gain}) * snap_s1.error;
	assign prod_i = $signed({1'b0, ki_gain}) * snap_s1.integral;

	// sum of products; floor and round-up flag give truncation toward zero
	assign acc = {prod_p_s2[56], prod_p_s2} + {prod_i_s2[56], prod_i_s2};

	// duty split from floor and round flag
	always_comb begin
		mag = '0;
		fwd = '0;
		rev = '0;
		if (!floor_s3[DriveW-1]) begin
			fwd = (|floor_s3[DriveW-2:8]) ? PWM_MAX : floor_s3[7:0];
		end else begin
			// magnitude of floor + round, i.e. ~floor + (1 - round)
			mag = ~floor_s3 + DriveW'(!round_s3);
			rev = (|mag[DriveW-1:8]) ? PWM_MAX : mag[7:0];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)  v_s1        <= push;
			if (s2_free)  v_s2        <= v_s1;
			if (s3_free)  v_s3        <= v_s2;
			if (out_free) out_valid_q <= v_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (s1_free && push) begin
			snap_s1 <= snap;
		end
		if (s2_free && v_s1) begin
			snap_s2   <= snap_s1;
			prod_p_s2 <= prod_p;
			prod_i_s2 <= prod_i;
		end
		if (s3_free && v_s2) begin
			snap_s3  <= snap_s2;
			floor_s3 <= acc[AccW-1:Q16_FRAC];
			round_s3 <= acc[AccW-1] && (|acc[Q16_FRAC-1:0]);
		end
		if (out_free && v_s3) begin
			snap_q <= snap_s3;
			fwd_q  <= fwd;
			rev_q  <= rev;
		end
	end

	assign out_valid       = out_valid_q;
	assign pwm_forward     = fwd_q;
	assign pwm_reverse     = rev_q;
	assign loop_error      = snap_q.error;
	assign position_now    = snap_q.position;
	assign bad_transitions = snap_q.bad;

endmodule

### sv/quadrature_pi_position_servo.sv
// ----------------------------------------------------------------------------
// quadrature_pi_position_servo
// Quadrature encoder position counter with a PI position loop and PWM split.
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction
//  ---------+--------------------------------------+-----------
//  input    | in_valid, in_stall, func, pin_a/b    | in
//  result   | out_valid, out_stall, pwm_*, ...     | out
//  config   | cfg_valid, cfg_ready, cfg_index/data | in
//
// One item is taken every cycle while in_stall is low; loop state updates at
// the transfer edge. A control tick's result is registered in turn in the
// snapshot, product, truncation and duty registers of the drive pipeline.
// Reset clears counters, loop state and gains to their defaults; no sweep.
// With the result side stalled, up to four tick results are held before
// in_stall rises; encoder samples make no result.
module quadrature_pi_position_servo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic               pin_a,
	input  logic               pin_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [7:0]  pwm_forward,
	output logic        [7:0]  pwm_reverse,
	output logic signed [31:0] loop_error,
	output logic signed [31:0] position_now,
	output logic        [31:0] bad_transitions,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [31:0] cfg_data
);
	import qpps_pkg::*;

	logic signed [31:0] target_q;
	logic        [23:0] kp_q;
	logic        [23:0] ki_q;
	logic               accept;
	logic               push_ready;
	logic signed [31:0] position;
	logic        [31:0] bad_count;
	logic signed [31:0] error_d;
	logic signed [31:0] integral_d;
	tick_snap_t         snap;

	// input transfer
	assign in_stall  = !push_ready;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			kp_q     <= KP_RESET;
			ki_q     <= KI_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TARGET: target_q <= cfg_data;
				CFG_KP:     kp_q     <= cfg_data[23:0];
				CFG_KI:     ki_q     <= cfg_data[23:0];
				default:    ;
			endcase
		end
	end

	// encoder counting
	qpps_encoder u_encoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_en (accept && !func),
		.pin_a     (pin_a),
		.pin_b     (pin_b),
		.position  (position),
		.bad_count (bad_count)
	);

	// loop error and integral
	qpps_pi_state u_pi_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_en    (accept && func),
		.target     (target_q),
		.position   (position),
		.error_d    (error_d),
		.integral_d (integral_d)
	);

	// tick snapshot into the drive pipeline
	always_comb begin
		snap.error    = error_d;
		snap.integral = integral_d;
		snap.position = position;
		snap.bad      = bad_count;
	end

	qpps_drive u_drive (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (accept && func),
		.push_ready      (push_ready),
		.snap            (snap),
		.kp_gain         (kp_q),
		.ki_gain         (ki_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pwm_forward     (pwm_forward),
		.pwm_reverse     (pwm_reverse),
		.loop_error      (loop_error),
		.position_now    (position_now),
		.bad_transitions (bad_transitions)
	);

`ifndef NO_ASSERTIONS
	// only one direction is ever driven
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pwm_forward == 8'd0 || pwm_reverse == 8'd0))
		else $error("both pwm duties nonzero");

	// an encoder sample moves exactly one of the two counters
	a_sample_moves_one: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !func) |=>
		((position != $past(position)) != (bad_count != $past(bad_count))))
		else $error("encoder sample did not move exactly one counter");

	// a control tick leaves the encoder counters alone
	a_tick_keeps_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func) |=> ($stable(position) && $stable(bad_count)))
		else $error("control tick changed encoder counters");

	// input is held back only when the result register is full
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with result register empty");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadrature PI position servo. Encoder samples
// and control ticks go in with random gaps, results come out under random
// stall, and every tick result is checked against a cycle-free servo model.
// ----------------------------------------------------------------------------
import qpps_pkg::*;

// item kinds on the func port
localparam bit FUNC_SAMPLE = 1'b0;
localparam bit FUNC_TICK   = 1'b1;

// one tick result as seen on the output ports
typedef struct {
	logic        [7:0]  fwd;
	logic        [7:0]  rev;
	logic signed [31:0] err;
	logic signed [31:0] pos;
	logic        [31:0] bad;
} tick_result_t;

// clamp to the signed 32-bit range
function automatic int clamp_s32(longint v);
	if (v > 64'sh7fff_ffff) begin
		return 32'sh7fff_ffff;
	end else if (v < -64'sh8000_0000) begin
		return 32'sh8000_0000;
	end
	return int'(v);
endfunction

// servo model plus the queue of tick results still owed by the block
class servo_checker;
	int           target;
	longint       kp_gain;
	longint       ki_gain;
	int           position;
	int unsigned  bad_count;
	bit           last_a;
	bit           last_b;
	int           err_held;
	int           integ;
	tick_result_t tick_results_q[$];
	int           mismatches;

	function new();
		target     = 0;
		kp_gain    = longint'(KP_RESET);
		ki_gain    = longint'(KI_RESET);
		position   = 0;
		bad_count  = 0;
		last_a     = 1'b0;
		last_b     = 1'b0;
		err_held   = 0;
		integ      = 0;
		mismatches = 0;
	endfunction

	// register write; indexes past the list change nothing
	function void note_config(logic [1:0] idx, logic [31:0] data);
		case (idx)
			CFG_TARGET: target = data;
			CFG_KP: kp_gain = longint'(data[23:0]);
			CFG_KI: ki_gain = longint'(data[23:0]);
			default: ;
		endcase
	endfunction

	// accepted input transfer: move the state, queue a result on a tick
	function void note_input(bit f, bit a, bit b);
		bit [1:0]     step;
		longint       acc;
		longint       drive;
		tick_result_t r;
		if (f == FUNC_SAMPLE) begin
			// cycle position is {a, a^b}: pins 00, 01, 11, 10 give 0, 1, 2, 3
			step = {a, a ^ b} - {last_a, last_a ^ last_b};
			if (step == 2'd1) begin
				position = position + 1;
			end else if (step == 2'd3) begin
				position = position - 1;
			end else begin
				bad_count = bad_count + 1;
			end
			last_a = a;
			last_b = b;
		end else begin
			integ    = clamp_s32(longint'(integ) + longint'(err_held));
			err_held = clamp_s32(longint'(target) - longint'(position));
			acc      = kp_gain * err_held + ki_gain * integ;
			drive    = acc / (longint'(1) << Q16_FRAC);
			r.fwd = 8'd0;
			r.rev = 8'd0;
			if (drive >= 0) begin
				r.fwd = (drive >= longint'(PWM_MAX)) ? PWM_MAX : drive[7:0];
			end else begin
				r.rev = (-drive >= longint'(PWM_MAX)) ? PWM_MAX : 8'(-drive);
			end
			r.err = err_held;
			r.pos = position;
			r.bad = bad_count;
			tick_results_q.push_back(r);
		end
	endfunction

	// accepted result transfer against the oldest owed result
	function void check_result(tick_result_t got);
		tick_result_t want;
		if (tick_results_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected result: fwd=%0d rev=%0d err=%0d pos=%0d bad=%0d",
					got.fwd, got.rev, got.err, got.pos, got.bad);
			end
			return;
		end
		want = tick_results_q.pop_front();
		if (got.fwd !== want.fwd || got.rev !== want.rev || got.err !== want.err ||
				got.pos !== want.pos || got.bad !== want.bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: expected fwd=%0d rev=%0d err=%0d pos=%0d bad=%0d",
					want.fwd, want.rev, want.err, want.pos, want.bad);
				$display("          actual   fwd=%0d rev=%0d err=%0d pos=%0d bad=%0d",
					got.fwd, got.rev, got.err, got.pos, got.bad);
			end
		end
	endfunction

	function int pending();
		return tick_results_q.size();
	endfunction
endclass

module testbench;

	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               func = 1'b0;
	logic               pin_a = 1'b0;
	logic               pin_b = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic        [7:0]  pwm_forward;
	logic        [7:0]  pwm_reverse;
	logic signed [31:0] loop_error;
	logic signed [31:0] position_now;
	logic        [31:0] bad_transitions;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic        [1:0]  cfg_index = 2'd0;
	logic        [31:0] cfg_data = 32'd0;

	servo_checker chk;
	bit           steady_in  = 1'b0;
	bit           steady_out = 1'b0;
	bit           squeeze    = 1'b0;
	bit   [1:0]   gen_ph     = 2'd0;

	quadrature_pi_position_servo dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.pin_a(pin_a),
		.pin_b(pin_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pwm_forward(pwm_forward),
		.pwm_reverse(pwm_reverse),
		.loop_error(loop_error),
		.position_now(position_now),
		.bad_transitions(bad_transitions),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 50 MHz clock
	initial begin
		forever #10 clk = ~clk;
	end

	// hard stop well past the slowest correct run
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// one input transfer; returns at the accepting edge with valid still high
	task automatic send_item(input bit f, input bit a, input bit b);
		int gap;
		gap = steady_in ? 0 : idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		pin_a    <= a;
		pin_b    <= b;
		do @(posedge clk); while (in_stall);
		chk.note_input(f, a, b);
		if (f == FUNC_SAMPLE) begin
			gen_ph = {a, a ^ b};
		end
	endtask

	// legal quadrature step, dir +1 forward and -1 reverse
	task automatic send_step(input int dir);
		bit [1:0] ph;
		ph = gen_ph + 2'(dir);
		send_item(FUNC_SAMPLE, ph[1], ph[1] ^ ph[0]);
	endtask

	task automatic send_tick();
		send_item(FUNC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// config write transfer, called with the input side idle
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		chk.note_config(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid, wait for every owed result, then cover the pipeline depth
	task automatic settle();
		in_valid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// two ticks that bring the integral back near zero with zero error held
	task automatic recenter_integral();
		int integ_a;
		settle();
		integ_a = clamp_s32(longint'(chk.integ) + longint'(chk.err_held));
		cfg_write(CFG_TARGET, clamp_s32(longint'(chk.position) - integ_a));
		send_tick();
		settle();
		cfg_write(CFG_TARGET, chk.position);
		send_tick();
		settle();
	endtask

	// mostly legal walks with runs of one direction, some ticks, some noise
	task automatic run_random(input int n_items);
		int dir;
		int r;
		dir = 1;
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			if (r < 22) begin
				send_tick();
			end else if (r < 88) begin
				if ($urandom_range(0, 9) == 0) begin
					dir = -dir;
				end
				send_step(dir);
			end else begin
				send_item(FUNC_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// result side: check each transfer and drive random stall
	initial begin
		tick_result_t got;
		int           hold_cycles;
		hold_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.fwd = pwm_forward;
				got.rev = pwm_reverse;
				got.err = loop_error;
				got.pos = position_now;
				got.bad = bad_transitions;
				chk.check_result(got);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				if (hold_cycles == 0) begin
					out_stall <= 1'b0;
				end
			end else if (squeeze) begin
				// long hold so the block fills up and stalls its input
				squeeze     = 1'b0;
				hold_cycles = 120;
				out_stall  <= 1'b1;
			end else if (!steady_out && $urandom_range(0, 3) == 0) begin
				hold_cycles = 1 + idle_gap();
				out_stall  <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		int p;
		chk = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default gains: tick from reset, first sample unchanged, a full forward cycle, reverse
		// steps and diagonal steps
		send_tick();
		send_item(FUNC_SAMPLE, 1'b0, 1'b0);
		send_item(FUNC_SAMPLE, 1'b0, 1'b1);
		send_item(FUNC_SAMPLE, 1'b1, 1'b1);
		send_item(FUNC_SAMPLE, 1'b1, 1'b0);
		send_item(FUNC_SAMPLE, 1'b0, 1'b0);
		send_item(FUNC_SAMPLE, 1'b1, 1'b1);
		send_item(FUNC_SAMPLE, 1'b0, 1'b1);
		send_item(FUNC_SAMPLE, 1'b0, 1'b0);
		send_item(FUNC_SAMPLE, 1'b1, 1'b0);
		send_item(FUNC_SAMPLE, 1'b0, 1'b1);
		send_tick();
		send_tick();

		// top target with negative position: error and integral hit the top
		settle();
		cfg_write(CFG_TARGET, 32'h7fff_ffff);
		cfg_write(CFG_KP, 32'hffff_ffff);
		cfg_write(CFG_KI, 32'hffff_ffff);
		send_item(FUNC_SAMPLE, 1'b0, 1'b0);
		send_item(FUNC_SAMPLE, 1'b1, 1'b0);
		send_item(FUNC_SAMPLE, 1'b1, 1'b1);
		repeat (3) send_tick();

		// bottom target with positive position: both saturate low
		settle();
		cfg_write(CFG_TARGET, 32'h8000_0000);
		cfg_write(CFG_KI, 32'h0000_0000);
		send_item(FUNC_SAMPLE, 1'b1, 1'b0);
		send_item(FUNC_SAMPLE, 1'b0, 1'b0);
		send_item(FUNC_SAMPLE, 1'b0, 1'b1);
		send_item(FUNC_SAMPLE, 1'b1, 1'b1);
		repeat (3) send_tick();

		// integral term alone, and a write past the register list
		settle();
		cfg_write(CFG_KP, 32'h0000_0000);
		cfg_write(CFG_KI, 32'h00ff_ffff);
		cfg_write(CFG_UNUSED, 32'hffff_ffff);
		send_tick();

		// random phases under different gain settings
		for (p = 0; p < 6; p++) begin
			recenter_integral();
			case (p)
				0: begin
					cfg_write(CFG_KP, $urandom_range(0, 32'h20000));
					cfg_write(CFG_KI, $urandom_range(0, 32'h200));
				end
				1: begin
					cfg_write(CFG_KP, $urandom());
					cfg_write(CFG_KI, $urandom());
					cfg_write(CFG_UNUSED, $urandom());
				end
				2: begin
					cfg_write(CFG_KP, 32'h0001_0000);
					cfg_write(CFG_KI, 32'h0000_0000);
				end
				3: begin
					cfg_write(CFG_KP, 32'h0000_0000);
					cfg_write(CFG_KI, $urandom_range(0, 32'h100));
				end
				4: begin
					cfg_write(CFG_KP, {8'd0, KP_RESET});
					cfg_write(CFG_KI, {8'd0, KI_RESET});
				end
				default: begin
					cfg_write(CFG_KP, $urandom_range(0, 32'h00ff_ffff));
					cfg_write(CFG_KI, $urandom_range(0, 32'h00ff_ffff));
				end
			endcase
			if (p == 1) begin
				cfg_write(CFG_TARGET, $urandom());
			end else begin
				cfg_write(CFG_TARGET, chk.position + $urandom_range(0, 400) - 200);
			end
			steady_in  = ($urandom_range(0, 3) == 0);
			steady_out = ($urandom_range(0, 3) == 0);
			run_random(90);
			if (p == 4) begin
				// back-to-back ticks against a long result hold
				steady_in = 1'b1;
				squeeze   = 1'b1;
				repeat (16) send_tick();
				steady_in = 1'b0;
			end
			run_random(90);
			steady_in  = 1'b0;
			steady_out = 1'b0;
		end

		settle();
		repeat (10) @(posedge clk);
		if (chk.mismatches == 0 && chk.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
